// ===== rtl/tactile_array_centroid_top_defines.svh =====
// Assertion macros for the tactile centroid block.
`ifndef TACTILE_ARRAY_CENTROID_TOP_DEFINES_SVH
`define TACTILE_ARRAY_CENTROID_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define TAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define TAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tac_pkg.sv =====
// Shared types, constants and helper functions for the tactile centroid block.
package tac_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_CH    = 9;
	localparam int SENS_W    = 16;
	localparam int W_W       = FRAC_BITS + 1;
	localparam int POS_W     = 12;
	localparam int SCALE_W   = 4;
	localparam int RAD_W     = 10;
	localparam int CEN_W     = 12;
	localparam int PROD_W    = W_W + POS_W;
	localparam int SUM_W     = PROD_W + 4;
	localparam int SW_W      = W_W + 4;
	localparam int SIDE_W    = 12;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [23:0] DIAG_NUM   = 24'd11863169;
	localparam int          DIAG_SHIFT = 24;

	typedef enum logic [1:0] {
		REG_IMAGE_SIDE   = 2'd0,
		REG_THRESHOLD    = 2'd1,
		REG_FULL_SCALE   = 2'd2,
		REG_SPECIAL_FS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SENS_W-1:0] sensor_0;
		logic [SENS_W-1:0] sensor_1;
		logic [SENS_W-1:0] sensor_2;
		logic [SENS_W-1:0] sensor_3;
		logic [SENS_W-1:0] sensor_4;
		logic [SENS_W-1:0] sensor_5;
		logic [SENS_W-1:0] sensor_6;
		logic [SENS_W-1:0] sensor_7;
		logic [SENS_W-1:0] sensor_8;
	} in_t;

	typedef struct packed {
		logic [CEN_W-1:0] centroid_x;
		logic [CEN_W-1:0] centroid_y;
		logic [RAD_W-1:0] radius_0;
		logic [RAD_W-1:0] radius_1;
		logic [RAD_W-1:0] radius_2;
		logic [RAD_W-1:0] radius_3;
		logic [RAD_W-1:0] radius_4;
		logic [RAD_W-1:0] radius_5;
		logic [RAD_W-1:0] radius_6;
		logic [RAD_W-1:0] radius_7;
		logic [RAD_W-1:0] radius_8;
	} out_t;

	// radii plus the empty-weight flag, carried alongside the centroid divide
	typedef struct packed {
		logic [NUM_CH-1:0][RAD_W-1:0] rad;
		logic                         sw_zero;
	} side_t;

	// canvas scale: floor(side / 500), side below 4096
	function automatic logic [SCALE_W-1:0] scale_of(input logic [SIDE_W-1:0] side);
		logic [SCALE_W-1:0] s;
		s = '0;
		for (int k = 1; k <= 8; k++) begin
			if (side >= SIDE_W'(500 * k)) begin
				s = SCALE_W'(k);
			end
		end
		return s;
	endfunction

	function automatic logic [39:0] diag_prod(input logic [SCALE_W-1:0] s);
		logic [39:0] m;
		m = 40'(s) * 40'd125;
		return m * 40'(DIAG_NUM);
	endfunction

	// diagonal offset, rounded down
	function automatic logic [POS_W-1:0] diag_floor(input logic [SCALE_W-1:0] s);
		logic [39:0] xn;
		xn = diag_prod(s);
		return POS_W'(xn >> DIAG_SHIFT);
	endfunction

	// diagonal offset, rounded up
	function automatic logic [POS_W-1:0] diag_ceil(input logic [SCALE_W-1:0] s);
		logic [39:0] xn;
		xn = diag_prod(s) + 40'((1 << DIAG_SHIFT) - 1);
		return POS_W'(xn >> DIAG_SHIFT);
	endfunction

endpackage

// ===== rtl/tac_lane.sv =====
// One channel lane: weight divider, weighted positions and marker radius.
module tac_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tac_pkg::SENS_W-1:0]  reading,
	input  logic [tac_pkg::SENS_W-1:0]  fs,
	input  logic [tac_pkg::SCALE_W-1:0] scale,
	input  logic [tac_pkg::POS_W-1:0]   px,
	input  logic [tac_pkg::POS_W-1:0]   py,
	output logic [tac_pkg::W_W-1:0]     w,
	output logic [tac_pkg::PROD_W-1:0]  wx,
	output logic [tac_pkg::PROD_W-1:0]  wy,
	output logic [tac_pkg::RAD_W-1:0]   rad
);
	import tac_pkg::*;

	logic [SENS_W-1:0] div_d;
	logic [SENS_W-1:0] m0;
	logic              q0;
	logic [SENS_W-1:0] rem_s [FRAC_BITS+1];
	logic [W_W-1:0]    quo_s [FRAC_BITS+1];
	logic [9:0]        s65;
	logic [W_W+9:0]    rprod;
	logic [W_W-1:0]    wf;

	// a zero full scale behaves as one
	assign div_d = (fs == '0) ? SENS_W'(1) : fs;
	assign m0    = (reading < div_d) ? reading : div_d;
	assign q0    = (m0 >= div_d);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= q0 ? (m0 - div_d) : m0;
			quo_s[0] <= W_W'(q0);
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
		logic [SENS_W:0] t;
		logic            b;
		assign t = {rem_s[k-1], 1'b0};
		assign b = (t >= {1'b0, div_d});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= b ? SENS_W'(t - {1'b0, div_d}) : SENS_W'(t);
				quo_s[k] <= {quo_s[k-1][W_W-2:0], b};
			end
		end
	end

	assign wf    = quo_s[FRAC_BITS];
	assign s65   = 10'(scale) * 10'd65;
	assign rprod = (W_W+10)'(s65) * (W_W+10)'(wf);

	always_ff @(posedge clk) begin
		if (en) begin
			w   <= wf;
			wx  <= PROD_W'(wf) * PROD_W'(px);
			wy  <= PROD_W'(wf) * PROD_W'(py);
			rad <= RAD_W'(10'(scale) * 10'd35 + 10'(rprod >> FRAC_BITS));
		end
	end

endmodule

// ===== rtl/tac_cdiv.sv =====
// Pipelined restoring divider for one centroid coordinate.
module tac_cdiv (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tac_pkg::SUM_W-1:0]  num,
	input  logic [tac_pkg::SW_W-1:0]   den,
	output logic [tac_pkg::CEN_W-1:0]  quo
);
	import tac_pkg::*;

	logic [SUM_W-1:0] rem_s [CEN_W];
	logic [SW_W-1:0]  den_s [CEN_W];
	logic [CEN_W-1:0] quo_s [CEN_W];

	for (genvar j = 0; j < CEN_W; j++) begin : g_stage
		localparam int BIT = CEN_W - 1 - j;
		logic [SUM_W-1:0] r_in;
		logic [SW_W-1:0]  d_in;
		logic [CEN_W-1:0] q_in;
		logic [SUM_W-1:0] sh;
		logic             b;
		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = quo_s[j-1];
		end
		assign sh = SUM_W'(d_in) << BIT;
		assign b  = (r_in >= sh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= b ? (r_in - sh) : r_in;
				den_s[j] <= d_in;
				quo_s[j] <= q_in | (CEN_W'(b) << BIT);
			end
		end
	end

	assign quo = quo_s[CEN_W-1];

endmodule

// ===== rtl/tactile_array_centroid_top.sv =====
// Top level: config port, nine weight lanes, merging sums, centroid divide, output.
// Pipeline from input transfer to result: 17 weight-divide stages, product,
// two adder stages, 12 centroid-divide stages, output register.
// Throughput: one frame per cycle; the whole pipeline holds only while a result is stalled.
// Frames with any reading at or below threshold give no result.
// Reset clears the pipeline valids and loads the registers with their defaults.
module tactile_array_centroid_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tac_pkg::ADDR_W-1:0] paddr,
	input  logic [tac_pkg::DATA_W-1:0] pwdata,
	output logic [tac_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tac_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tac_pkg::out_t              out_data
);
	import tac_pkg::*;
	`include "tactile_array_centroid_top_defines.svh"

	localparam int LANE_LAT = FRAC_BITS + 2;
	localparam int DEPTH    = LANE_LAT + 2 + CEN_W + 1;

	// configuration registers
	logic [SIDE_W-1:0] side_q;
	logic [SENS_W-1:0] thr_q;
	logic [SENS_W-1:0] fs_q;
	logic [SENS_W-1:0] sfs_q;
	reg_idx_t          widx;

	logic                 en;
	logic                 pass;
	logic [DEPTH-1:0]     vld_q;
	logic [SENS_W-1:0]    rd    [NUM_CH];
	logic [POS_W-1:0]     px    [NUM_CH];
	logic [POS_W-1:0]     py    [NUM_CH];
	logic [W_W-1:0]       ln_w  [NUM_CH];
	logic [PROD_W-1:0]    ln_wx [NUM_CH];
	logic [PROD_W-1:0]    ln_wy [NUM_CH];
	logic [RAD_W-1:0]     ln_r  [NUM_CH];

	logic [SCALE_W-1:0]   scale;
	logic [POS_W-1:0]     half, p125, p250, p375, lo, hi;
	logic [POS_W:0]       cx_max;

	logic [SW_W-1:0]      sw_s1 [3];
	logic [SUM_W-1:0]     sx_s1 [3];
	logic [SUM_W-1:0]     sy_s1 [3];
	logic [NUM_CH-1:0][RAD_W-1:0] rad_s1;
	logic [SW_W-1:0]      sw_s2;
	logic [SUM_W-1:0]     sx_s2;
	logic [SUM_W-1:0]     sy_s2;
	side_t                side_s2;
	side_t                dly_q [CEN_W];
	logic [CEN_W-1:0]     cx, cy;
	out_t                 out_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(1000);
			thr_q  <= SENS_W'(30);
			fs_q   <= SENS_W'(1000);
			sfs_q  <= SENS_W'(250);
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_IMAGE_SIDE: side_q <= pwdata[SIDE_W-1:0];
				REG_THRESHOLD:  thr_q  <= pwdata[SENS_W-1:0];
				REG_FULL_SCALE: fs_q   <= pwdata[SENS_W-1:0];
				REG_SPECIAL_FS: sfs_q  <= pwdata[SENS_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_IMAGE_SIDE: prdata = DATA_W'(side_q);
			REG_THRESHOLD:  prdata = DATA_W'(thr_q);
			REG_FULL_SCALE: prdata = DATA_W'(fs_q);
			REG_SPECIAL_FS: prdata = DATA_W'(sfs_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- canvas geometry, static between writes ----------------
	assign scale = scale_of(side_q);
	assign half  = POS_W'(side_q >> 1);
	assign p125  = POS_W'(scale) * POS_W'(125);
	assign p250  = POS_W'(scale) * POS_W'(250);
	assign p375  = POS_W'(scale) * POS_W'(375);
	assign hi    = half + diag_floor(scale);
	assign lo    = half - diag_ceil(scale);

	// bound on the centroid x, one bit wider so the sum cannot wrap
	assign cx_max = {1'b0, half} + {1'b0, p375};

	always_comb begin
		px[0] = lo;   py[0] = hi;
		px[1] = p250; py[1] = p125;
		px[2] = hi;   py[2] = hi;
		px[3] = p125; py[3] = p250;
		px[4] = p250; py[4] = p250;
		px[5] = p375; py[5] = p250;
		px[6] = lo;   py[6] = lo;
		px[7] = p250; py[7] = p375;
		px[8] = hi;   py[8] = lo;
	end

	// ---------------- input side ----------------
	// The whole pipeline moves unless the output holds a stalled result.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		rd[0] = in_data.sensor_0;
		rd[1] = in_data.sensor_1;
		rd[2] = in_data.sensor_2;
		rd[3] = in_data.sensor_3;
		rd[4] = in_data.sensor_4;
		rd[5] = in_data.sensor_5;
		rd[6] = in_data.sensor_6;
		rd[7] = in_data.sensor_7;
		rd[8] = in_data.sensor_8;
		pass  = 1'b1;
		for (int k = 0; k < NUM_CH; k++) begin
			if (rd[k] <= thr_q) begin
				pass = 1'b0;
			end
		end
	end

	// rejected frames never enter the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid && pass};
		end
	end

	// ---------------- lanes ----------------
	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		tac_lane u_lane (
			.clk     (clk),
			.en      (en),
			.reading (rd[k]),
			.fs      ((k == 7) ? sfs_q : fs_q),
			.scale   (scale),
			.px      (px[k]),
			.py      (py[k]),
			.w       (ln_w[k]),
			.wx      (ln_wx[k]),
			.wy      (ln_wy[k]),
			.rad     (ln_r[k])
		);
	end

	// ---------------- merge: two adder stages ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < 3; g++) begin
				sw_s1[g] <= SW_W'(ln_w[3*g]) + SW_W'(ln_w[3*g+1]) + SW_W'(ln_w[3*g+2]);
				sx_s1[g] <= SUM_W'(ln_wx[3*g]) + SUM_W'(ln_wx[3*g+1])
					+ SUM_W'(ln_wx[3*g+2]);
				sy_s1[g] <= SUM_W'(ln_wy[3*g]) + SUM_W'(ln_wy[3*g+1])
					+ SUM_W'(ln_wy[3*g+2]);
			end
			for (int k = 0; k < NUM_CH; k++) begin
				rad_s1[k] <= ln_r[k];
			end
			sw_s2           <= sw_s1[0] + sw_s1[1] + sw_s1[2];
			sx_s2           <= sx_s1[0] + sx_s1[1] + sx_s1[2];
			sy_s2           <= sy_s1[0] + sy_s1[1] + sy_s1[2];
			side_s2.rad     <= rad_s1;
			side_s2.sw_zero <= (sw_s1[0] + sw_s1[1] + sw_s1[2]) == '0;
		end
	end

	// ---------------- centroid divide ----------------
	tac_cdiv u_cdiv_x (.clk(clk), .en(en), .num(sx_s2), .den(sw_s2), .quo(cx));
	tac_cdiv u_cdiv_y (.clk(clk), .en(en), .num(sy_s2), .den(sw_s2), .quo(cy));

	// radii and the empty flag travel in step with the divide
	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= side_s2;
			for (int j = 1; j < CEN_W; j++) begin
				dly_q[j] <= dly_q[j-1];
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.centroid_x <= dly_q[CEN_W-1].sw_zero ? CEN_W'(p250) : cx;
			out_q.centroid_y <= dly_q[CEN_W-1].sw_zero ? CEN_W'(p250) : cy;
			out_q.radius_0   <= dly_q[CEN_W-1].rad[0];
			out_q.radius_1   <= dly_q[CEN_W-1].rad[1];
			out_q.radius_2   <= dly_q[CEN_W-1].rad[2];
			out_q.radius_3   <= dly_q[CEN_W-1].rad[3];
			out_q.radius_4   <= dly_q[CEN_W-1].rad[4];
			out_q.radius_5   <= dly_q[CEN_W-1].rad[5];
			out_q.radius_6   <= dly_q[CEN_W-1].rad[6];
			out_q.radius_7   <= dly_q[CEN_W-1].rad[7];
			out_q.radius_8   <= dly_q[CEN_W-1].rad[8];
		end
	end

	assign out_valid = vld_q[DEPTH-1];
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	`TAC_ASSERT_NEXT(a_reject, in_valid && !in_stall && !pass, !vld_q[0], "rejected frame entered")
	`TAC_ASSERT_NOW(a_cx_range, out_valid, out_data.centroid_x <= cx_max, "centroid x out of range")
	`TAC_ASSERT_NOW(a_rad_min, out_valid, out_data.radius_4 >= RAD_W'(scale) * RAD_W'(35), "radius below base")

endmodule
